// ----- rtl/sme_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit package
// Shared constants, opcodes, error codes and sequencer states.
// ----------------------------------------------------------------------------
package sme_pkg;

    localparam int STACK_DEPTH   = 1024;
    localparam int PROGRAM_DEPTH = 4096;
    localparam int SAW           = $clog2(STACK_DEPTH);   // stack address width
    localparam int SPW           = SAW + 1;               // stack pointer width
    localparam int PCW           = 13;                    // program counter width
    localparam int DW            = 32;                    // data word width

    typedef enum logic [4:0] {
        OP_EXIT  = 5'd0,  OP_PUSH  = 5'd1,  OP_ADD   = 5'd2,  OP_SUB  = 5'd3,
        OP_MUL   = 5'd4,  OP_DIV   = 5'd5,  OP_POW   = 5'd6,  OP_NOT  = 5'd7,
        OP_NEG   = 5'd8,  OP_EQ    = 5'd9,  OP_NE    = 5'd10, OP_LT   = 5'd11,
        OP_LE    = 5'd12, OP_GT    = 5'd13, OP_GE    = 5'd14, OP_LOAD = 5'd15,
        OP_STORE = 5'd16, OP_POP   = 5'd17, OP_DUP   = 5'd18, OP_PRINT = 5'd19,
        OP_JMP   = 5'd20, OP_JT    = 5'd21, OP_JF    = 5'd22
    } t_op;

    typedef enum logic [2:0] {
        ERR_NONE   = 3'd0, ERR_UNDER = 3'd1, ERR_OVER = 3'd2, ERR_DIV0 = 3'd3,
        ERR_INDEX  = 3'd4, ERR_OPCODE = 3'd5, ERR_JUMP = 3'd6, ERR_POW = 3'd7
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE, S_RDB, S_RDA, S_RDX, S_EXEC, S_DIV, S_POW, S_FIN
    } t_state;

endpackage

// ----- rtl/sme_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sme_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/stack_machine_execute_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit
// Executes one stack-machine instruction per input transaction.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries one instruction per transaction: the opcode in
// i_s_tuser and the signed immediate in i_s_tdata. The master stream returns
// one result per instruction: next pc, halted, print flag and value, and an
// error code. program_length is written through i_cfg_wr_en/i_cfg_wr_data
// while the unit is idle.
// An instruction reads the stack memory three times through its single read
// port, then executes; the next instruction is accepted only after its result
// has moved to the output register. Divide runs a restoring divider one
// quotient bit per cycle; power runs the shared 32x32 multiplier once per
// cycle until the magnitude saturates or the exponent is used up. Once the
// unit is stopped or its pc has reached the program length, an instruction
// skips the reads and execution and goes straight to its final step.
// A new instruction is accepted while the previous result still waits in
// the output register; if the receiver stalls, the unit holds the next
// result in its final step until the output register frees up.
// Reset clears pc, stack pointer, stopped flag and program_length; the stack
// memory contents are not cleared.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [12:0] i_cfg_wr_data,     // program_length
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,         // [31:0] operand
    input  logic [4:0]  i_s_tuser,         // [4:0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [12:0] next_pc, [13] halted, [14] print_valid, [46:15] print_value,
    // [49:47] error_code, [55:50] zero
    output logic [55:0] o_m_tdata
);

    localparam int PCW = sme_pkg::PCW;
    localparam int SPW = sme_pkg::SPW;
    localparam int SAW = sme_pkg::SAW;
    localparam int DW  = sme_pkg::DW;

    sme_pkg::t_state r_state, n_state;

    // Architectural state.
    logic [PCW-1:0] r_plen;
    logic [PCW-1:0] r_pc;
    logic [SPW-1:0] r_sp;
    logic           r_stopped;

    // Instruction and operands.
    logic [4:0]     r_func;
    logic [DW-1:0]  r_opnd;
    logic [DW-1:0]  r_a, r_b;

    // Pending result.
    logic [DW-1:0]  r_res, n_res;
    sme_pkg::t_err  r_err, n_err;
    logic           r_we, n_we;
    logic [SAW-1:0] r_waddr, n_waddr;
    logic [SPW-1:0] r_nsp, n_nsp;
    logic [PCW-1:0] r_npc, n_npc;
    logic           r_halt, n_halt;
    logic           r_pval, n_pval;

    // Shared iterative unit registers.
    logic [DW-1:0]  r_q, n_q;
    logic [DW:0]    r_rem, n_rem;
    logic [DW-1:0]  r_dvs, n_dvs;
    logic [DW:0]    r_mag, n_mag;
    logic [DW-2:0]  r_cnt, n_cnt;
    logic           r_neg, n_neg;

    // Output register.
    logic           r_ovalid;
    logic [55:0]    r_odata;

    // Stack memory interface.
    logic [SAW-1:0] ram_raddr;
    logic [DW-1:0]  ram_rdata;
    logic           ram_we;

    logic [PCW-1:0] len;
    logic           out_free;
    logic [DW-1:0]  mul_x, mul_y;
    logic [2*DW-1:0] mul_p;
    logic [DW:0]    rem_sh;
    logic [DW-1:0]  mag_a, mag_b;
    logic           idx_bad;
    logic [PCW+20:0] jt;
    logic [PCW-1:0] pc_inc;
    logic           take;

    assign len = (r_plen > PCW'(sme_pkg::PROGRAM_DEPTH)) ?
                 PCW'(sme_pkg::PROGRAM_DEPTH) : r_plen;
    assign out_free   = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == sme_pkg::S_IDLE);
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // Stack memory.
    assign ram_we = (r_state == sme_pkg::S_FIN) && out_free && r_we &&
                    (r_err == sme_pkg::ERR_NONE);

    sme_ram #(.WIDTH(DW), .DEPTH(sme_pkg::STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_waddr),
        .i_wdata (r_res),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Read address by step: top, next below top, then the indexed entry.
    always_comb begin
        case (r_state)
            sme_pkg::S_RDB: ram_raddr = r_sp[SAW-1:0] - SAW'(1);
            sme_pkg::S_RDA: ram_raddr = r_sp[SAW-1:0] - SAW'(2);
            default:        ram_raddr = r_opnd[SAW-1:0];
        endcase
    end

    // Shared multiplier: plain multiply in execute, magnitude steps in power.
    assign mul_x = (r_state == sme_pkg::S_POW) ? r_mag[DW-1:0] : r_a;
    assign mul_y = (r_state == sme_pkg::S_POW) ? r_dvs : r_b;
    assign mul_p = mul_x * mul_y;

    assign rem_sh = {r_rem[DW-1:0], r_q[DW-1]};
    assign mag_a  = r_a[DW-1] ? (DW'(0) - r_a) : r_a;
    assign mag_b  = r_b[DW-1] ? (DW'(0) - r_b) : r_b;
    assign idx_bad = r_opnd[DW-1] || (r_opnd >= DW'(r_sp));
    assign pc_inc = r_pc + PCW'(1);
    assign jt = (PCW+21)'(r_pc) + (PCW+21)'(1) +
                {{(PCW-11){r_opnd[DW-1]}}, r_opnd};

    // Sequencer.
    always_comb begin
        n_state = r_state;
        n_res = r_res;  n_err = r_err;  n_we = r_we;  n_waddr = r_waddr;
        n_nsp = r_nsp;  n_npc = r_npc;  n_halt = r_halt;  n_pval = r_pval;
        n_q = r_q;  n_rem = r_rem;  n_dvs = r_dvs;  n_mag = r_mag;
        n_cnt = r_cnt;  n_neg = r_neg;
        take = 1'b1;
        case (r_state)
            sme_pkg::S_IDLE: begin
                if (i_s_tvalid) begin
                    n_err = sme_pkg::ERR_NONE;
                    n_we = 1'b0;
                    n_pval = 1'b0;
                    n_res = '0;
                    n_nsp = r_sp;
                    n_npc = r_pc;
                    n_halt = 1'b1;
                    n_state = (r_stopped || r_pc >= len) ? sme_pkg::S_FIN
                                                         : sme_pkg::S_RDB;
                end
            end
            sme_pkg::S_RDB: n_state = sme_pkg::S_RDA;
            sme_pkg::S_RDA: n_state = sme_pkg::S_RDX;
            sme_pkg::S_RDX: n_state = sme_pkg::S_EXEC;
            sme_pkg::S_EXEC: begin
                n_state = sme_pkg::S_FIN;
                n_npc = pc_inc;
                n_halt = 1'b0;
                case (r_func)
                    sme_pkg::OP_EXIT: begin
                        n_npc = r_pc;
                        n_halt = 1'b1;
                    end
                    sme_pkg::OP_PUSH, sme_pkg::OP_LOAD, sme_pkg::OP_DUP: begin
                        if (r_func == sme_pkg::OP_DUP && r_sp == '0)
                            n_err = sme_pkg::ERR_UNDER;
                        else if (r_func == sme_pkg::OP_LOAD && idx_bad)
                            n_err = sme_pkg::ERR_INDEX;
                        else if (r_sp >= SPW'(sme_pkg::STACK_DEPTH))
                            n_err = sme_pkg::ERR_OVER;
                        n_we = 1'b1;
                        n_waddr = r_sp[SAW-1:0];
                        n_nsp = r_sp + SPW'(1);
                        n_res = (r_func == sme_pkg::OP_PUSH) ? r_opnd :
                                (r_func == sme_pkg::OP_DUP) ? r_b : ram_rdata;
                    end
                    sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL,
                    sme_pkg::OP_DIV, sme_pkg::OP_POW, sme_pkg::OP_EQ,
                    sme_pkg::OP_NE, sme_pkg::OP_LT, sme_pkg::OP_LE,
                    sme_pkg::OP_GT, sme_pkg::OP_GE: begin
                        n_we = 1'b1;
                        n_waddr = r_sp[SAW-1:0] - SAW'(2);
                        n_nsp = r_sp - SPW'(1);
                        if (r_sp < SPW'(2)) begin
                            n_err = sme_pkg::ERR_UNDER;
                        end else begin
                            case (r_func)
                                sme_pkg::OP_ADD: n_res = r_a + r_b;
                                sme_pkg::OP_SUB: n_res = r_a - r_b;
                                sme_pkg::OP_MUL: n_res = mul_p[DW-1:0];
                                sme_pkg::OP_DIV: begin
                                    if (r_b == '0) begin
                                        n_err = sme_pkg::ERR_DIV0;
                                    end else begin
                                        n_q = mag_a;
                                        n_rem = '0;
                                        n_dvs = mag_b;
                                        n_cnt = (DW-1)'(DW);
                                        n_neg = r_a[DW-1] ^ r_b[DW-1];
                                        n_state = sme_pkg::S_DIV;
                                    end
                                end
                                sme_pkg::OP_POW: begin
                                    if (r_b == '0 || r_a == DW'(1)) begin
                                        n_res = DW'(1);
                                    end else if (r_a == '1) begin
                                        n_res = r_b[0] ? '1 : DW'(1);
                                    end else if (r_a == '0) begin
                                        n_res = '0;
                                        if (r_b[DW-1]) n_err = sme_pkg::ERR_POW;
                                    end else if (r_b[DW-1]) begin
                                        n_res = '0;
                                    end else begin
                                        n_mag = (DW+1)'(1);
                                        n_dvs = mag_a;
                                        n_cnt = r_b[DW-2:0];
                                        n_neg = r_a[DW-1] && r_b[0];
                                        n_state = sme_pkg::S_POW;
                                    end
                                end
                                sme_pkg::OP_EQ: n_res = DW'(r_a == r_b);
                                sme_pkg::OP_NE: n_res = DW'(r_a != r_b);
                                sme_pkg::OP_LT: n_res = DW'($signed(r_a) < $signed(r_b));
                                sme_pkg::OP_LE: n_res = DW'($signed(r_a) <= $signed(r_b));
                                sme_pkg::OP_GT: n_res = DW'($signed(r_a) > $signed(r_b));
                                default:        n_res = DW'($signed(r_a) >= $signed(r_b));
                            endcase
                        end
                    end
                    sme_pkg::OP_NOT, sme_pkg::OP_NEG: begin
                        if (r_sp == '0) n_err = sme_pkg::ERR_UNDER;
                        n_we = 1'b1;
                        n_waddr = r_sp[SAW-1:0] - SAW'(1);
                        n_res = (r_func == sme_pkg::OP_NOT) ? DW'(r_b == '0)
                                                            : DW'(0) - r_b;
                    end
                    sme_pkg::OP_STORE: begin
                        if (r_sp == '0) n_err = sme_pkg::ERR_UNDER;
                        else if (idx_bad) n_err = sme_pkg::ERR_INDEX;
                        n_we = 1'b1;
                        n_waddr = r_opnd[SAW-1:0];
                        n_res = r_b;
                        n_nsp = r_sp - SPW'(1);
                    end
                    sme_pkg::OP_POP, sme_pkg::OP_PRINT: begin
                        if (r_sp == '0) n_err = sme_pkg::ERR_UNDER;
                        n_nsp = r_sp - SPW'(1);
                        n_pval = (r_func == sme_pkg::OP_PRINT);
                        n_res = r_b;
                    end
                    sme_pkg::OP_JMP, sme_pkg::OP_JT, sme_pkg::OP_JF: begin
                        if (r_func != sme_pkg::OP_JMP) begin
                            n_nsp = r_sp - SPW'(1);
                            if (r_sp == '0) n_err = sme_pkg::ERR_UNDER;
                            take = (r_func == sme_pkg::OP_JT) ? (r_b != '0)
                                                              : (r_b == '0);
                        end
                        if (r_sp != '0 || r_func == sme_pkg::OP_JMP) begin
                            if (take) begin
                                if (jt[PCW+20] || jt > (PCW+21)'(len))
                                    n_err = sme_pkg::ERR_JUMP;
                                n_npc = jt[PCW-1:0];
                            end
                        end
                    end
                    default: n_err = sme_pkg::ERR_OPCODE;
                endcase
            end
            sme_pkg::S_DIV: begin
                // One restoring step per cycle.
                n_q = {r_q[DW-2:0], 1'b0};
                n_rem = rem_sh;
                if (rem_sh >= {1'b0, r_dvs}) begin
                    n_rem = rem_sh - {1'b0, r_dvs};
                    n_q[0] = 1'b1;
                end
                n_cnt = r_cnt - (DW-1)'(1);
                if (r_cnt == (DW-1)'(1)) begin
                    n_res = r_neg ? (DW'(0) - n_q) : n_q;
                    n_state = sme_pkg::S_FIN;
                end
            end
            sme_pkg::S_POW: begin
                // One multiply per cycle until exponent ends or value saturates.
                if (r_cnt == '0 || r_mag > (DW+1)'(33'h0_8000_0000)) begin
                    if (r_neg)
                        n_res = (r_mag >= (DW+1)'(33'h0_8000_0000)) ?
                                32'h8000_0000 : DW'(0) - r_mag[DW-1:0];
                    else
                        n_res = (r_mag > (DW+1)'(33'h0_7FFF_FFFF)) ?
                                32'h7FFF_FFFF : r_mag[DW-1:0];
                    n_state = sme_pkg::S_FIN;
                end else begin
                    n_mag = (mul_p > 64'h8000_0000) ? (DW+1)'(33'h1_0000_0000)
                                                    : mul_p[DW:0];
                    n_cnt = r_cnt - (DW-1)'(1);
                end
            end
            sme_pkg::S_FIN: begin
                if (out_free) n_state = sme_pkg::S_IDLE;
            end
            default: n_state = sme_pkg::S_IDLE;
        endcase
    end

    // State register and control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= sme_pkg::S_IDLE;
            r_plen    <= '0;
            r_pc      <= '0;
            r_sp      <= '0;
            r_stopped <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) r_plen <= i_cfg_wr_data;
            if (r_state == sme_pkg::S_FIN && out_free) begin
                r_ovalid <= 1'b1;
                if (r_err != sme_pkg::ERR_NONE) begin
                    r_stopped <= 1'b1;
                end else begin
                    r_pc <= r_npc;
                    r_sp <= r_nsp;
                    if (r_halt || r_npc >= len) r_stopped <= 1'b1;
                end
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;  r_err <= n_err;  r_we <= n_we;  r_waddr <= n_waddr;
        r_nsp <= n_nsp;  r_npc <= n_npc;  r_halt <= n_halt;  r_pval <= n_pval;
        r_q <= n_q;  r_rem <= n_rem;  r_dvs <= n_dvs;  r_mag <= n_mag;
        r_cnt <= n_cnt;  r_neg <= n_neg;
        if (r_state == sme_pkg::S_IDLE && i_s_tvalid) begin
            r_func <= i_s_tuser;
            r_opnd <= i_s_tdata;
        end
        if (r_state == sme_pkg::S_RDA) r_b <= ram_rdata;
        if (r_state == sme_pkg::S_RDX) r_a <= ram_rdata;
        if (r_state == sme_pkg::S_FIN && out_free) begin
            if (r_err != sme_pkg::ERR_NONE) begin
                r_odata <= {6'd0, r_err, 32'd0, 1'b0, 1'b1, r_pc};
            end else begin
                r_odata <= {6'd0, sme_pkg::ERR_NONE,
                            (r_pval ? r_res : 32'd0), r_pval,
                            (r_halt || r_npc >= len), r_npc};
            end
        end
    end

endmodule

// ----- tb/sv/stack_machine_execute_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stack machine execute unit testbench
// Streams instruction sequences into the unit and checks every result against
// a cycle-free predictor of the pc, the stack and the stopped flag. Sequences
// are built from the predicted state so that long programs run without
// faulting. One terminating case (exit, an error, normal end or a shortened
// program) ends each run, followed by a few ignored instructions.
// ----------------------------------------------------------------------------
module stack_machine_execute_unit_tb;

    localparam int          LIMIT_CYCLES   = 2000000;
    localparam int          RANDOM_ITEMS   = 1950;
    localparam int          NUM_PHASES     = 6;
    localparam logic [4:0]  FIRST_BAD_OP   = 5'd23;
    localparam logic [12:0] LENGTH_MAX     = 13'h1FFF;

    // Predictor of the execute unit plus the queue of results still owed.
    class exec_scoreboard;
        int unsigned   prog_len;
        int unsigned   pc;
        int unsigned   sp;
        bit            stopped;
        logic [31:0]   stk [sme_pkg::STACK_DEPTH];
        logic [55:0]   owed_results [$];
        int            mismatches;
        int            checked;

        function new();
            prog_len   = 0;
            pc         = 0;
            sp         = 0;
            stopped    = 0;
            mismatches = 0;
            checked    = 0;
        endfunction

        function int unsigned eff_len();
            return (prog_len < sme_pkg::PROGRAM_DEPTH) ? prog_len : sme_pkg::PROGRAM_DEPTH;
        endfunction

        // Exact integer power, saturated to the int32 range of the true sign.
        function logic [31:0] int_power(longint b, longint e, inout sme_pkg::t_err err);
            longint unsigned mag;
            longint unsigned base;
            longint          i;
            if (e == 0) return 32'd1;
            if (b == 1) return 32'd1;
            if (b == -1) return e[0] ? 32'hFFFF_FFFF : 32'd1;
            if (b == 0) begin
                if (e < 0) err = sme_pkg::ERR_POW;
                return 32'd0;
            end
            if (e < 0) return 32'd0;
            base = (b < 0) ? -b : b;
            mag  = 1;
            for (i = 0; i < e && mag <= 64'h8000_0000; i++) mag = mag * base;
            if (b < 0 && e[0])
                return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(mag));
            return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
        endfunction

        // Works out the result of one accepted instruction and updates state.
        function void note_input(logic [4:0] f, logic [31:0] op);
            int unsigned   ln;
            int unsigned   nsp;
            int unsigned   npc;
            sme_pkg::t_err err;
            bit            halt;
            bit            pvalid;
            logic [31:0]   pval;
            logic [31:0]   a;
            logic [31:0]   b;
            logic [31:0]   r;
            longint        sa;
            longint        sb;
            longint        sop;
            longint        tgt;
            bit            take;
            ln = eff_len();
            if (stopped || pc >= ln) begin
                stopped = 1;
                owed_results.push_back({6'd0, sme_pkg::ERR_NONE, 32'd0, 1'b0, 1'b1,
                                        pc[12:0]});
                return;
            end
            b      = (sp >= 1) ? stk[sp - 1] : 32'd0;
            a      = (sp >= 2) ? stk[sp - 2] : 32'd0;
            sa     = longint'($signed(a));
            sb     = longint'($signed(b));
            sop    = longint'($signed(op));
            nsp    = sp;
            npc    = pc + 1;
            err    = sme_pkg::ERR_NONE;
            halt   = 0;
            pvalid = 0;
            pval   = 32'd0;
            r      = 32'd0;
            case (f)
                sme_pkg::OP_EXIT: begin
                    halt = 1;
                    npc  = pc;
                end
                sme_pkg::OP_PUSH, sme_pkg::OP_LOAD, sme_pkg::OP_DUP: begin
                    if (f == sme_pkg::OP_DUP && sp < 1) err = sme_pkg::ERR_UNDER;
                    else if (f == sme_pkg::OP_LOAD && (sop < 0 || sop >= longint'(sp)))
                        err = sme_pkg::ERR_INDEX;
                    else if (sp >= sme_pkg::STACK_DEPTH) err = sme_pkg::ERR_OVER;
                    else begin
                        stk[sp] = (f == sme_pkg::OP_PUSH) ? op :
                                  (f == sme_pkg::OP_DUP) ? b : stk[op[9:0]];
                        nsp = sp + 1;
                    end
                end
                sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV,
                sme_pkg::OP_POW, sme_pkg::OP_EQ, sme_pkg::OP_NE, sme_pkg::OP_LT,
                sme_pkg::OP_LE, sme_pkg::OP_GT, sme_pkg::OP_GE: begin
                    if (sp < 2) err = sme_pkg::ERR_UNDER;
                    else begin
                        case (f)
                            sme_pkg::OP_ADD: r = a + b;
                            sme_pkg::OP_SUB: r = a - b;
                            sme_pkg::OP_MUL: r = a * b;
                            sme_pkg::OP_DIV: begin
                                if (sb == 0) err = sme_pkg::ERR_DIV0;
                                else r = 32'(sa / sb);
                            end
                            sme_pkg::OP_POW: r = int_power(sa, sb, err);
                            sme_pkg::OP_EQ:  r = {31'd0, sa == sb};
                            sme_pkg::OP_NE:  r = {31'd0, sa != sb};
                            sme_pkg::OP_LT:  r = {31'd0, sa < sb};
                            sme_pkg::OP_LE:  r = {31'd0, sa <= sb};
                            sme_pkg::OP_GT:  r = {31'd0, sa > sb};
                            default: r = {31'd0, sa >= sb};
                        endcase
                        if (err == sme_pkg::ERR_NONE) begin
                            stk[sp - 2] = r;
                            nsp = sp - 1;
                        end
                    end
                end
                sme_pkg::OP_NOT, sme_pkg::OP_NEG: begin
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else stk[sp - 1] = (f == sme_pkg::OP_NOT) ? {31'd0, b == 32'd0}
                                                              : 32'd0 - b;
                end
                sme_pkg::OP_STORE: begin
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else if (sop < 0 || sop >= longint'(sp)) err = sme_pkg::ERR_INDEX;
                    else begin
                        stk[op[9:0]] = b;
                        nsp = sp - 1;
                    end
                end
                sme_pkg::OP_POP, sme_pkg::OP_PRINT: begin
                    if (sp < 1) err = sme_pkg::ERR_UNDER;
                    else begin
                        nsp = sp - 1;
                        if (f == sme_pkg::OP_PRINT) begin
                            pvalid = 1;
                            pval   = b;
                        end
                    end
                end
                sme_pkg::OP_JMP, sme_pkg::OP_JT, sme_pkg::OP_JF: begin
                    take = 1;
                    if (f != sme_pkg::OP_JMP) begin
                        if (sp < 1) err = sme_pkg::ERR_UNDER;
                        else take = (f == sme_pkg::OP_JT) ? (b != 0) : (b == 0);
                    end
                    if (err == sme_pkg::ERR_NONE && take) begin
                        tgt = longint'(pc) + 1 + sop;
                        if (tgt < 0 || tgt > longint'(ln)) err = sme_pkg::ERR_JUMP;
                        else npc = int'(tgt);
                    end
                    if (err == sme_pkg::ERR_NONE && f != sme_pkg::OP_JMP) nsp = sp - 1;
                end
                default: err = sme_pkg::ERR_OPCODE;
            endcase
            if (err != sme_pkg::ERR_NONE) begin
                halt   = 1;
                npc    = pc;
                pvalid = 0;
                pval   = 32'd0;
                nsp    = sp;
            end else if (npc >= ln) begin
                halt = 1;
            end
            sp = nsp;
            pc = npc;
            if (halt) stopped = 1;
            owed_results.push_back({6'd0, err, pval, pvalid, halt, npc[12:0]});
        endfunction

        // Compares one accepted result with the oldest owed result.
        function void check_result(logic [55:0] got);
            logic [55:0] want;
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %h", got);
                return;
            end
            want = owed_results.pop_front();
            checked++;
            if (got[12:0] !== want[12:0] || got[13] !== want[13] || got[14] !== want[14] ||
                got[46:15] !== want[46:15] || got[49:47] !== want[49:47] ||
                got[55:50] !== want[55:50]) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d: exp pc=%0d halt=%b pv=%b val=%h err=%0d | %s",
                             checked, want[12:0], want[13], want[14], want[46:15],
                             want[49:47], $sformatf("got pc=%0d halt=%b pv=%b val=%h err=%0d z=%h",
                             got[12:0], got[13], got[14], got[46:15], got[49:47], got[55:50]));
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [12:0] i_cfg_wr_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [4:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [55:0] o_m_tdata;

    exec_scoreboard sb;
    int             cycles;
    int             burst_left;
    int             long_hold_req;
    int             hold_left;
    int             rx_mode;
    int             ending_case;

    stack_machine_execute_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_s_tdata     (i_s_tdata),
        .i_s_tuser     (i_s_tuser),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata)
    );

    // Clock.
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Cycle count with a hard limit.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("FAIL stack_machine_execute_unit");
            $finish;
        end
    end

    // Result monitor: one result transaction per handshake.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // Receiver backpressure: changing stall pattern, plus one long hold on request.
    always @(negedge i_clk) begin
        if (long_hold_req != 0) begin
            hold_left     = long_hold_req;
            long_hold_req = 0;
        end
        if (cycles % 97 == 0) rx_mode = $urandom_range(0, 3);
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready = 1'b0;
        end else begin
            case (rx_mode)
                0: i_m_tready = 1'b1;
                1: i_m_tready = $urandom_range(0, 1);
                2: i_m_tready = ($urandom_range(0, 7) != 0);
                default: i_m_tready = ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // Drives one instruction and records it when accepted. Called at a falling edge.
    task automatic send_instr(logic [4:0] f, logic [31:0] op);
        if (burst_left <= 0) begin
            i_s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 30);
        end
        i_s_tvalid = 1'b1;
        i_s_tdata  = op;
        i_s_tuser  = f;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(f, op);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Stops offering and waits until every owed result has come back.
    task automatic wait_drained();
        i_s_tvalid = 1'b0;
        while (sb.owed_results.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_length(logic [12:0] v);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = v;
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        sb.prog_len = v;
    endtask

    function automatic logic [31:0] push_value();
        int pick;
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 12)) - 4);
            2: begin
                pick = $urandom_range(0, 4);
                return (pick == 0) ? 32'h7FFF_FFFF : (pick == 1) ? 32'h8000_0000 :
                       (pick == 2) ? 32'd0 : (pick == 3) ? 32'hFFFF_FFFF : 32'd1;
            end
            default: return $urandom_range(0, 1) ? $urandom_range(0, 40)
                                                : -$urandom_range(0, 40);
        endcase
    endfunction

    // True when the instruction runs without faulting in the predicted state.
    function automatic bit can_run(logic [4:0] f);
        logic [31:0] a;
        logic [31:0] b;
        b = (sb.sp >= 1) ? sb.stk[sb.sp - 1] : 32'd0;
        a = (sb.sp >= 2) ? sb.stk[sb.sp - 2] : 32'd0;
        case (f)
            sme_pkg::OP_PUSH: return sb.sp < sme_pkg::STACK_DEPTH;
            sme_pkg::OP_LOAD, sme_pkg::OP_DUP:
                return sb.sp >= 1 && sb.sp < sme_pkg::STACK_DEPTH;
            sme_pkg::OP_DIV: return sb.sp >= 2 && b != 0;
            sme_pkg::OP_POW: return sb.sp >= 2 && !(a == 0 && b[31]);
            sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_EQ,
            sme_pkg::OP_NE, sme_pkg::OP_LT, sme_pkg::OP_LE, sme_pkg::OP_GT,
            sme_pkg::OP_GE:
                return sb.sp >= 2;
            sme_pkg::OP_NOT, sme_pkg::OP_NEG, sme_pkg::OP_STORE, sme_pkg::OP_POP,
            sme_pkg::OP_PRINT, sme_pkg::OP_JT, sme_pkg::OP_JF:
                return sb.sp >= 1;
            sme_pkg::OP_JMP: return 1;
            default: return 0;
        endcase
    endfunction

    // Sends one non-faulting instruction; want_op < 0 picks one at random.
    task automatic send_legal(int want_op);
        logic [4:0]  f;
        logic [31:0] op;
        logic [31:0] b;
        int unsigned ln;
        int unsigned tgt;
        bit          take;
        ln = sb.eff_len();
        if (sb.pc + 2 >= ln) want_op = sme_pkg::OP_JMP;
        f = 5'(want_op);
        if (want_op < 0 || !can_run(f)) begin
            do begin
                if (sb.sp < 3 && $urandom_range(0, 1)) f = sme_pkg::OP_PUSH;
                else if (sb.sp > 1000) f = sme_pkg::OP_POP;
                else f = 5'($urandom_range(sme_pkg::OP_PUSH, sme_pkg::OP_JF));
            end while (!can_run(f));
        end
        b   = (sb.sp >= 1) ? sb.stk[sb.sp - 1] : 32'd0;
        tgt = $urandom_range(0, ln - 1);
        op  = $urandom;
        case (f)
            sme_pkg::OP_PUSH: op = push_value();
            sme_pkg::OP_LOAD, sme_pkg::OP_STORE: op = $urandom_range(0, sb.sp - 1);
            sme_pkg::OP_JMP: op = tgt - sb.pc - 1;
            sme_pkg::OP_JT, sme_pkg::OP_JF: begin
                take = (f == sme_pkg::OP_JT) ? (b != 0) : (b == 0);
                if (take) op = tgt - sb.pc - 1;
            end
            default: ;
        endcase
        send_instr(f, op);
    endtask

    // Ends execution through the terminating case picked at the start of the run.
    task automatic send_ending();
        int unsigned ln;
        send_instr(sme_pkg::OP_JMP, -(sb.pc + 1));
        ln = sb.eff_len();
        case (ending_case)
            0: send_instr(sme_pkg::OP_EXIT, $urandom);
            1: begin
                while (sb.sp > 0) send_instr(sme_pkg::OP_POP, $urandom);
                send_instr($urandom_range(0, 1) ? sme_pkg::OP_PRINT : sme_pkg::OP_ADD,
                           $urandom);
            end
            2: begin
                while (sb.sp < sme_pkg::STACK_DEPTH) send_instr(sme_pkg::OP_PUSH, $urandom);
                send_instr($urandom_range(0, 1) ? sme_pkg::OP_PUSH : sme_pkg::OP_DUP,
                           $urandom);
            end
            3: begin
                send_instr(sme_pkg::OP_PUSH, push_value());
                send_instr(sme_pkg::OP_PUSH, 32'd0);
                send_instr(sme_pkg::OP_DIV, $urandom);
            end
            4: begin
                if (sb.sp == 0) send_instr(sme_pkg::OP_PUSH, push_value());
                send_instr($urandom_range(0, 1) ? sme_pkg::OP_LOAD : sme_pkg::OP_STORE,
                           $urandom_range(0, 1) ? sb.sp + $urandom_range(0, 9)
                                                : (32'h8000_0000 | $urandom));
            end
            5: send_instr(5'($urandom_range(FIRST_BAD_OP, 31)), $urandom);
            6: send_instr(sme_pkg::OP_JMP,
                          $urandom_range(0, 1) ? ln + 1 - sb.pc - 1 : -(sb.pc + 2));
            7: begin
                send_instr(sme_pkg::OP_PUSH, 32'd0);
                send_instr(sme_pkg::OP_PUSH, -$urandom_range(1, 100));
                send_instr(sme_pkg::OP_POW, $urandom);
            end
            8: send_instr(sme_pkg::OP_JMP, ln - sb.pc - 1);
            default: begin
                wait_drained();
                write_length(13'd0);
                send_instr(sme_pkg::OP_PUSH, $urandom);
            end
        endcase
        // Instructions after the stop are ignored by the unit.
        repeat (6) send_instr(5'($urandom), $urandom);
    endtask

    initial begin
        int          phase;
        int          n;
        int          n_rand;
        logic [12:0] len_val;
        sb            = new();
        cycles        = 0;
        burst_left    = 0;
        long_hold_req = 0;
        hold_left     = 0;
        rx_mode       = 0;
        // Filling the stack for the overflow ending costs a full stack of pushes,
        // so the random phases give those items up.
        ending_case   = $urandom_range(0, 9);
        n_rand        = (ending_case == 2) ? RANDOM_ITEMS - sme_pkg::STACK_DEPTH
                                           : RANDOM_ITEMS;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 13'd0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = 32'd0;
        i_s_tuser     = 5'd0;
        i_m_tready    = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        write_length(LENGTH_MAX);

        // Directed: field extremes, then a legal attempt at each operation but exit.
        send_instr(sme_pkg::OP_PUSH, 32'h7FFF_FFFF);
        send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
        send_instr(sme_pkg::OP_SUB, 32'hFFFF_FFFF);
        send_instr(sme_pkg::OP_PUSH, 32'h8000_0000);
        send_instr(sme_pkg::OP_PUSH, 32'hFFFF_FFFF);
        send_instr(sme_pkg::OP_DIV, 32'h0000_0000);
        for (int f = sme_pkg::OP_PUSH; f <= sme_pkg::OP_JF; f++) send_legal(f);

        // Random programs over several program lengths.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: len_val = LENGTH_MAX;
                1: len_val = 13'(sme_pkg::PROGRAM_DEPTH);
                2: len_val = 13'(sb.pc + 3);
                default: len_val = 13'($urandom_range(sb.pc + 2, LENGTH_MAX));
            endcase
            write_length(len_val);
            for (n = 0; n < n_rand / NUM_PHASES; n++) begin
                if (phase == 1 && n == 20) long_hold_req = 400;
                send_legal(-1);
            end
        end
        wait_drained();
        write_length(LENGTH_MAX);
        send_ending();

        wait_drained();
        repeat (50) @(negedge i_clk);
        $display("Checked %0d results over %0d program lengths; ending case %0d.",
                 sb.checked, NUM_PHASES + 2, ending_case);
        if (sb.mismatches == 0 && sb.owed_results.size() == 0) begin
            $display("PASS stack_machine_execute_unit");
        end else begin
            $display("Mismatches: %0d, results still owed: %0d",
                     sb.mismatches, sb.owed_results.size());
            $display("FAIL stack_machine_execute_unit");
        end
        $finish;
    end

endmodule
